@@ src/tick_event_scheduler_defines.svh @@
// ----------------------------------------------------------------------------
// tick event scheduler assertion macros
// shared property shapes for the checker, sampled on clk, idle in reset
// ----------------------------------------------------------------------------
`ifndef TICK_EVENT_SCHEDULER_DEFINES_SVH
`define TICK_EVENT_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define TES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/tes_pkg.sv @@
// ----------------------------------------------------------------------------
// tes_pkg
// types and constants shared by the tick event scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package tes_pkg;

  // payload widths
  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 32;
  localparam int UNI_W      = 16;
  localparam int DELAY_W    = 14;
  localparam int RESET_W    = 16;
  localparam int KIND_W     = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // input command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCHED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ARM   = 2'd2;

  // event kinds
  localparam logic [KIND_W-1:0] EV_REPLY     = 2'd0;
  localparam logic [KIND_W-1:0] EV_COLOUR    = 2'd1;
  localparam logic [KIND_W-1:0] EV_DISCOVERY = 2'd2;
  localparam logic [KIND_W-1:0] EV_RESET     = 2'd3;

  // register index of enable
  localparam logic [CFG_ADDR_W-3:0] REG_ENABLE = 1'b0;

  // command queue geometry
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // classified operation carried to the back end
  typedef enum logic [1:0] {
    OP_TICK,
    OP_SCHED,
    OP_ARM
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  addr;
    logic [UNI_W-1:0]   uni;
    logic [DELAY_W-1:0] delay;
    logic               data_rx;
    logic [RESET_W-1:0] reset_ticks;
  } cmd_t;

  // queue status toward the producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // back end sequencer
  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

@@ src/tes_in_if.sv @@
// ----------------------------------------------------------------------------
// tes_in_if
// command channel: valid/ready handshake with the command payload
// ----------------------------------------------------------------------------
`default_nettype none

interface tes_in_if;
  import tes_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [ADDR_W-1:0]  peer_address;
  logic [UNI_W-1:0]   universe_in;
  logic [DELAY_W-1:0] delay_ticks;
  logic               data_received;
  logic [RESET_W-1:0] reset_ticks;

  modport source (
    output valid, cmd, peer_address, universe_in, delay_ticks, data_received, reset_ticks,
    input  ready
  );

  modport sink (
    input  valid, cmd, peer_address, universe_in, delay_ticks, data_received, reset_ticks,
    output ready
  );
endinterface

`default_nettype wire

@@ src/tes_out_if.sv @@
// ----------------------------------------------------------------------------
// tes_out_if
// event channel: valid/ready handshake with the event payload
// ----------------------------------------------------------------------------
`default_nettype none

interface tes_out_if;
  import tes_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [ADDR_W-1:0] reply_address;
  logic [UNI_W-1:0]  reply_universe;
  logic              last;

  modport source (
    output valid, event_kind, reply_address, reply_universe, last,
    input  ready
  );

  modport sink (
    input  valid, event_kind, reply_address, reply_universe, last,
    output ready
  );
endinterface

`default_nettype wire

@@ src/tes_queue.sv @@
// ----------------------------------------------------------------------------
// tes_queue
// two-entry command queue between the front and back ends
// ----------------------------------------------------------------------------
`default_nettype none

module tes_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tes_pkg::cmd_t  push_cmd,
  input  wire logic           pop,
  output tes_pkg::cmd_t       head,
  output tes_pkg::q_stat_t    stat
);
  import tes_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  // status and head entry
  always_comb begin
    stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
    stat.empty = (count_r == '0);
    head       = mem_r[rd_ptr_r];
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (!do_push && do_pop) count_r <= count_r - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end
endmodule

`default_nettype wire

@@ src/tes_front.sv @@
// ----------------------------------------------------------------------------
// tes_front
// accepts command beats, classifies them and feeds the command queue
// ----------------------------------------------------------------------------
`default_nettype none

module tes_front (
  tes_in_if.sink             in_bus,
  input  wire tes_pkg::q_stat_t q_stat,
  output logic               push,
  output tes_pkg::cmd_t      push_cmd
);
  import tes_pkg::*;

  logic accept;

  // take a beat whenever the queue has room
  assign in_bus.ready = !q_stat.full;
  assign accept       = in_bus.valid && in_bus.ready;

  // classify; the unused code is dropped here
  always_comb begin
    push_cmd.op          = OP_TICK;
    push_cmd.addr        = in_bus.peer_address;
    push_cmd.uni         = in_bus.universe_in;
    push_cmd.delay       = in_bus.delay_ticks;
    push_cmd.data_rx     = in_bus.data_received;
    push_cmd.reset_ticks = in_bus.reset_ticks;
    push                 = 1'b0;
    unique case (in_bus.cmd)
      CMD_TICK: begin
        push_cmd.op = OP_TICK;
        push        = accept;
      end
      CMD_SCHED: begin
        push_cmd.op = OP_SCHED;
        push        = accept;
      end
      CMD_ARM: begin
        push_cmd.op = OP_ARM;
        push        = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end
endmodule

`default_nettype wire

@@ src/tes_back.sv @@
// ----------------------------------------------------------------------------
// tes_back
// executes queued commands: slot table, dividers, reset countdown, events
// ----------------------------------------------------------------------------
`default_nettype none

module tes_back #(
  parameter int SLOT_COUNT            = 8,
  parameter int COLOUR_PERIOD_LOG2    = 12,
  parameter int DISCOVERY_PERIOD_LOG2 = 18
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             enable,
  input  wire tes_pkg::cmd_t    head,
  input  wire tes_pkg::q_stat_t q_stat,
  output logic                  pop,
  tes_out_if.source             out_bus
);
  import tes_pkg::*;

  localparam int EV_W       = SLOT_COUNT + 3;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  state_t                           state_r;
  state_t                           state_nxt;
  logic [DELAY_W-1:0]               cd_r   [SLOT_COUNT];
  logic [ADDR_W-1:0]                addr_r [SLOT_COUNT];
  logic [UNI_W-1:0]                 uni_r  [SLOT_COUNT];
  logic [COLOUR_PERIOD_LOG2-1:0]    col_div_r;
  logic [DISCOVERY_PERIOD_LOG2-1:0] disc_div_r;
  logic [RESET_W-1:0]               rst_cd_r;
  logic [EV_W-1:0]                  ev_mask_r;
  logic [EV_W-1:0]                  ev_mask_nxt;

  logic                             out_valid_r;
  logic [KIND_W-1:0]                out_kind_r;
  logic [ADDR_W-1:0]                out_addr_r;
  logic [UNI_W-1:0]                 out_uni_r;
  logic                             out_last_r;

  logic                             tick;
  logic                             sched;
  logic                             arm;
  logic                             emit;
  logic                             free_found;
  logic [SLOT_IDX_W-1:0]            free_idx;
  logic [SLOT_COUNT-1:0]            slot_fire;
  logic                             col_fire;
  logic                             disc_fire;
  logic                             rst_fire;
  logic [EV_W-1:0]                  tick_mask;
  logic [EV_W-1:0]                  ev_low;
  logic [EV_W-1:0]                  ev_rest;
  logic [SLOT_IDX_W-1:0]            ev_idx;
  logic [KIND_W-1:0]                ev_kind;

  // first free slot for a schedule
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (cd_r[i] == '0) begin
        free_found = 1'b1;
        free_idx   = SLOT_IDX_W'(i);
      end
    end
  end

  // what fires on this tick, colour first and reset last
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_fire[i] = (cd_r[i] == DELAY_W'(1));
    end
    col_fire  = (col_div_r == '0) && !head.data_rx;
    disc_fire = (disc_div_r == '0);
    rst_fire  = (rst_cd_r == RESET_W'(1));
    tick_mask = {rst_fire, slot_fire, disc_fire, col_fire};
  end

  // lowest pending event and its kind
  always_comb begin
    ev_low  = ev_mask_r & (~ev_mask_r + EV_W'(1));
    ev_rest = ev_mask_r & ~ev_low;
    ev_idx  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (ev_low[i + 2]) ev_idx = SLOT_IDX_W'(i);
    end
    if (ev_low[0])         ev_kind = EV_COLOUR;
    else if (ev_low[1])    ev_kind = EV_DISCOVERY;
    else if (ev_low[EV_W-1]) ev_kind = EV_RESET;
    else                   ev_kind = EV_REPLY;
  end

  // sequencer outputs
  always_comb begin
    pop   = 1'b0;
    emit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        pop = !q_stat.empty;
      end
      ST_EMIT: begin
        emit = !out_valid_r || out_bus.ready;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
    tick  = pop && (head.op == OP_TICK) && enable;
    sched = pop && (head.op == OP_SCHED);
    arm   = pop && (head.op == OP_ARM);
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (tick && (tick_mask != '0)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit && (ev_rest == '0)) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // pending event mask
  always_comb begin
    ev_mask_nxt = ev_mask_r;
    if (tick)      ev_mask_nxt = tick_mask;
    else if (emit) ev_mask_nxt = ev_rest;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ev_mask_r  <= '0;
      col_div_r  <= COLOUR_PERIOD_LOG2'(1);
      disc_div_r <= DISCOVERY_PERIOD_LOG2'(1);
      rst_cd_r   <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        cd_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      ev_mask_r <= ev_mask_nxt;
      if (tick) begin
        col_div_r  <= col_div_r + 1'b1;
        disc_div_r <= disc_div_r + 1'b1;
        if (rst_cd_r != '0) rst_cd_r <= rst_cd_r - 1'b1;
      end else if (arm) begin
        rst_cd_r <= head.reset_ticks;
      end
      // slot countdowns step together on a tick
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (tick && (cd_r[i] != '0)) begin
          cd_r[i] <= cd_r[i] - 1'b1;
        end else if (sched && free_found && (free_idx == SLOT_IDX_W'(i))) begin
          cd_r[i] <= head.delay;
        end
      end
    end
  end

  // slot address and universe
  always_ff @(posedge clk) begin
    if (sched && free_found) begin
      addr_r[free_idx] <= head.addr;
      uni_r[free_idx]  <= head.uni;
    end else if (emit && (ev_kind == EV_REPLY)) begin
      addr_r[ev_idx] <= '0;
      uni_r[ev_idx]  <= '0;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= ev_kind;
      out_last_r <= (ev_rest == '0);
      if (ev_kind == EV_REPLY) begin
        out_addr_r <= addr_r[ev_idx];
        out_uni_r  <= uni_r[ev_idx];
      end else begin
        out_addr_r <= '0;
        out_uni_r  <= '0;
      end
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.event_kind     = out_kind_r;
  assign out_bus.reply_address  = out_addr_r;
  assign out_bus.reply_universe = out_uni_r;
  assign out_bus.last           = out_last_r;
endmodule

`default_nettype wire

@@ src/tick_event_scheduler.sv @@
// A command beat is written into the command queue before the back end pops it; the
// first event of a tick passes the event mask register, then the output register.
// The back end pops no new command while it emits the events of a tick (up to
// SLOT_COUNT+3) one at a time through the single event register, stalling on ready.
// Reset (synchronous, rst_n low): all slots free, dividers at one, reset countdown
// disarmed, enable off, queue and output register empty.
// ----------------------------------------------------------------------------
// tick_event_scheduler
// tick-driven scheduler of reply, colour, discovery and reset events
// ----------------------------------------------------------------------------
`default_nettype none

module tick_event_scheduler #(
  parameter int SLOT_COUNT            = 8,
  parameter int COLOUR_PERIOD_LOG2    = 12,
  parameter int DISCOVERY_PERIOD_LOG2 = 18
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  tes_in_if.sink                                  in_bus,
  tes_out_if.source                               out_bus,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [tes_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [tes_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [tes_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                    pready
);
  import tes_pkg::*;

  logic    enable_r;
  logic    cfg_wr;
  logic    push;
  logic    pop;
  cmd_t    push_cmd;
  cmd_t    head;
  q_stat_t q_stat;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_wr && (paddr[CFG_ADDR_W-1:2] == REG_ENABLE)) begin
      enable_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1:2] == REG_ENABLE) prdata[0] = enable_r;
  end

  // front end
  tes_front u_front (
    .in_bus   (in_bus),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // command queue
  tes_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // back end
  tes_back #(
    .SLOT_COUNT            (SLOT_COUNT),
    .COLOUR_PERIOD_LOG2    (COLOUR_PERIOD_LOG2),
    .DISCOVERY_PERIOD_LOG2 (DISCOVERY_PERIOD_LOG2)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .enable  (enable_r),
    .head    (head),
    .q_stat  (q_stat),
    .pop     (pop),
    .out_bus (out_bus)
  );
endmodule

`default_nettype wire

@@ src/tes_checker.sv @@
// ----------------------------------------------------------------------------
// tes_checker
// port-level checks on the event channel and the configuration port
// ----------------------------------------------------------------------------
`default_nettype none

`include "tick_event_scheduler_defines.svh"

module tes_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [tes_pkg::KIND_W-1:0]         event_kind,
  input wire logic [tes_pkg::ADDR_W-1:0]         reply_address,
  input wire logic [tes_pkg::UNI_W-1:0]          reply_universe,
  input wire logic                               psel,
  input wire logic                               penable,
  input wire logic                               pwrite,
  input wire logic [tes_pkg::CFG_ADDR_W-1:0]     paddr,
  input wire logic [tes_pkg::CFG_DATA_W-1:0]     pwdata,
  input wire logic [tes_pkg::CFG_DATA_W-1:0]     prdata,
  input wire logic                               pready
);
  import tes_pkg::*;

  // a stalled event beat stays offered
  `TES_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "event beat dropped while stalled")

  // only reply events carry an address or universe
  `TES_ASSERT_NOW(a_zero_payload, out_valid && (event_kind != EV_REPLY), (reply_address == '0) && (reply_universe == '0), "non-reply event with payload")

  // enable reads back what was last written
  `TES_ASSERT_NEXT(a_enable_rdbk, psel && penable && pwrite && (paddr[CFG_ADDR_W-1:2] == REG_ENABLE), prdata[0] == $past(pwdata[0]), "enable readback mismatch")

  // the configuration port never waits
  `TES_ASSERT_NOW(a_pready, psel && penable, pready, "configuration access stalled")
endmodule

bind tick_event_scheduler tes_checker u_tes_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .event_kind     (out_bus.event_kind),
  .reply_address  (out_bus.reply_address),
  .reply_universe (out_bus.reply_universe),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata),
  .pready         (pready)
);

`default_nettype wire
